>>> hw/rtl/gqmrw_pkg.sv
`default_nettype none

package gqmrw_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int GLYPH_ROWS          = 8;
  localparam int GLYPH_COUNT         = 36;

  // Mode codes carried on the command channel.
  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  localparam logic [7:0] CHAR_DIGIT_FIRST = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_LAST  = 8'h39;
  localparam logic [7:0] CHAR_LOWER_FIRST = 8'h61;
  localparam logic [7:0] CHAR_LOWER_LAST  = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_FIRST = 8'h41;
  localparam logic [7:0] CHAR_UPPER_LAST  = 8'h5a;

  // Glyph numbers: digits first, then lower-case letters.
  localparam logic [5:0] GLYPH_LOWER_BASE = 6'd10;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
  } cmd_t;

  typedef struct packed {
    logic [3:0] row_address;
    logic [7:0] row_pattern;
    logic       last_row;
  } frame_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  // Font ROM, one 64-bit word per glyph, top row in the most significant byte.
  localparam logic [63:0] GLYPH_FONT [GLYPH_COUNT] = '{
    64'h1c2222222222221c, 64'h081808080808081c, 64'h1c2222040810203e,
    64'h1c22020c0202221c, 64'h040c1414241e0404, 64'h3e20203c0202221c,
    64'h1c22203c2222221c, 64'h3e24040808080808, 64'h1c22221c2222221c,
    64'h1c2222221e02221c,
    64'h3c42023e42463a00, 64'he060607c6666dc00, 64'h000078ccc0cc7800,
    64'h1c0c0c7ccccc7600, 64'h000078ccfcc07800, 64'h386c60f06060f000,
    64'h000076cccc7c0cf8, 64'he0606c766666e600, 64'h3000703030307800,
    64'h0c000c0c0ccccc78, 64'he060666c786ce600, 64'h7030303030307800,
    64'h0000ccfefed6c600, 64'h0000f8cccccccc00, 64'h0078cccccccc7800,
    64'h00dc66667c60f000, 64'h0076cccc7c0c1e00, 64'h00dc766660f00000,
    64'h007cc0780cf80000, 64'h10307c3030341800, 64'h00cccccccccc7600,
    64'h00cccccccc783000, 64'h00c6d6fefe6c0000, 64'h00c66c386cc60000,
    64'h00cccccccc7c0cf8, 64'h00fc983064fc0000
  };

endpackage

`default_nettype wire

>>> hw/rtl/gqmrw_stream_if.sv
`default_nettype none

interface gqmrw_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/glyph_queue_matrix_row_writer.sv
// Character queue in front of an 8x8 LED matrix.
// The cmd channel takes one item per accepted handshake. With mode at enqueue,
// a digit or a letter is written into the character queue; other
// bytes are dropped, and so is any byte that arrives while the queue is full.
// Enqueue items can be taken in every cycle while no tick is being handled.
// With mode at tick, the oldest character is popped. A digit or a lower-case
// letter then produces eight frame items on the frame channel, rows 1 to 8,
// the eighth one flagged as the last row. An upper-case letter is discarded.
// A tick on an empty queue does nothing. Otherwise the popped character is
// read from the registered queue memory port in the read state, and only a
// glyph character then goes on to the emit state, which sends its rows.
// While a glyph is being sent, cmd ready stays low. When the receiver stalls,
// the frame output register holds its item and row sequencing waits. cmd
// becomes ready again as soon as the last row is loaded into that register.
// Synchronous reset empties the queue and clears the output valid flag; the
// queue memory itself is not cleared since every read follows a write.
`default_nettype none

module glyph_queue_matrix_row_writer #(
  parameter int QUEUE_DEPTH = gqmrw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  gqmrw_stream_if.sink    cmd,
  gqmrw_stream_if.source  frame
);
  import gqmrw_pkg::*;

  localparam int PtrW   = $clog2(QUEUE_DEPTH);
  localparam int CountW = $clog2(QUEUE_DEPTH + 1);

  // Queue storage: one write port, one registered read port.
  logic [7:0] char_fifo [QUEUE_DEPTH];
  logic [7:0] rd_data;

  logic [PtrW-1:0]   read_pointer;
  logic [PtrW-1:0]   write_pointer;
  logic [CountW-1:0] fill_count;

  state_t     state;
  state_t     state_next;
  logic [2:0] row;
  logic [5:0] glyph_sel;
  logic [5:0] glyph_sel_next;

  logic   out_valid;
  frame_t out_data;

  logic cmd_fire;
  logic char_ok;
  logic do_push;
  logic do_pop;
  logic glyph_hit;
  logic load_frame;
  logic [63:0] font_word;

  assign cmd_fire = cmd.valid && cmd.ready;

  assign char_ok =
    (cmd.data.char_code >= CHAR_DIGIT_FIRST && cmd.data.char_code <= CHAR_DIGIT_LAST) ||
    (cmd.data.char_code >= CHAR_LOWER_FIRST && cmd.data.char_code <= CHAR_LOWER_LAST) ||
    (cmd.data.char_code >= CHAR_UPPER_FIRST && cmd.data.char_code <= CHAR_UPPER_LAST);

  // Classification of the character that came back from the queue memory.
  always_comb begin
    glyph_hit      = 1'b0;
    glyph_sel_next = '0;
    if (rd_data >= CHAR_DIGIT_FIRST && rd_data <= CHAR_DIGIT_LAST) begin
      glyph_hit      = 1'b1;
      glyph_sel_next = 6'(rd_data - CHAR_DIGIT_FIRST);
    end else if (rd_data >= CHAR_LOWER_FIRST && rd_data <= CHAR_LOWER_LAST) begin
      glyph_hit      = 1'b1;
      glyph_sel_next = 6'(rd_data - CHAR_LOWER_FIRST) + GLYPH_LOWER_BASE;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = (state == ST_IDLE);
    do_push    = 1'b0;
    do_pop     = 1'b0;
    load_frame = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          if (cmd.data.mode == MODE_TICK) begin
            if (fill_count != '0) begin
              do_pop     = 1'b1;
              state_next = ST_READ;
            end
          end else if (char_ok && fill_count != CountW'(QUEUE_DEPTH)) begin
            do_push = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_next = glyph_hit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid || frame.ready) begin
          load_frame = 1'b1;
          if (row == 3'd7) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      char_fifo[write_pointer] <= cmd.data.char_code;
    end
    if (do_pop) begin
      rd_data <= char_fifo[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      read_pointer  <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
      row           <= '0;
    end else begin
      state <= state_next;
      if (do_push) begin
        write_pointer <= (write_pointer == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : write_pointer + 1'b1;
        fill_count    <= fill_count + 1'b1;
      end
      if (do_pop) begin
        read_pointer <= (read_pointer == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                 : read_pointer + 1'b1;
        fill_count   <= fill_count - 1'b1;
      end
      if (state == ST_READ) begin
        row <= '0;
      end else if (load_frame) begin
        row <= row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      glyph_sel <= glyph_sel_next;
    end
  end

  // Row bytes are taken from the top of the font word downward.
  assign font_word = GLYPH_FONT[glyph_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_frame) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_frame) begin
      out_data.row_address <= {1'b0, row} + 4'd1;
      out_data.row_pattern <= font_word[{~row, 3'b000} +: 8];
      out_data.last_row    <= (row == 3'd7);
    end
  end

  assign frame.valid = out_valid;
  assign frame.data  = out_data;

endmodule

`default_nettype wire

>>> bench/gqmrw_row_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts the frames that each accepted command causes
// and compares them in order with the frames that the block sends.
module gqmrw_row_checker #(
  parameter int DEPTH = gqmrw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_ready,
  input  gqmrw_pkg::cmd_t   cmd_data,
  input  logic              frame_valid,
  input  logic              frame_ready,
  input  gqmrw_pkg::frame_t frame_data,
  output int                fail_count,
  output int                pending_rows
);
  import gqmrw_pkg::*;

  // Digits 0 to 9, then letters a to z; top row in the high byte.
  localparam logic [63:0] BITMAPS [36] = '{
    64'h1c2222222222221c, 64'h081808080808081c, 64'h1c2222040810203e,
    64'h1c22020c0202221c, 64'h040c1414241e0404, 64'h3e20203c0202221c,
    64'h1c22203c2222221c, 64'h3e24040808080808, 64'h1c22221c2222221c,
    64'h1c2222221e02221c,
    64'h3c42023e42463a00, 64'he060607c6666dc00, 64'h000078ccc0cc7800,
    64'h1c0c0c7ccccc7600, 64'h000078ccfcc07800, 64'h386c60f06060f000,
    64'h000076cccc7c0cf8, 64'he0606c766666e600, 64'h3000703030307800,
    64'h0c000c0c0ccccc78, 64'he060666c786ce600, 64'h7030303030307800,
    64'h0000ccfefed6c600, 64'h0000f8cccccccc00, 64'h0078cccccccc7800,
    64'h00dc66667c60f000, 64'h0076cccc7c0c1e00, 64'h00dc766660f00000,
    64'h007cc0780cf80000, 64'h10307c3030341800, 64'h00cccccccccc7600,
    64'h00cccccccc783000, 64'h00c6d6fefe6c0000, 64'h00c66c386cc60000,
    64'h00cccccccc7c0cf8, 64'h00fc983064fc0000
  };

  logic [7:0] char_store [DEPTH];
  int         rd_ptr;
  int         wr_ptr;
  int         fill;
  frame_t     expected_rows [$];
  int         mismatches = 0;

  assign fail_count = mismatches;

  task automatic report(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic bit is_digit(input logic [7:0] ch);
    return ch >= CHAR_DIGIT_FIRST && ch <= CHAR_DIGIT_LAST;
  endfunction

  function automatic bit is_lower(input logic [7:0] ch);
    return ch >= CHAR_LOWER_FIRST && ch <= CHAR_LOWER_LAST;
  endfunction

  function automatic bit is_upper(input logic [7:0] ch);
    return ch >= CHAR_UPPER_FIRST && ch <= CHAR_UPPER_LAST;
  endfunction

  // Applies one command to the predicted queue and lines up its frames.
  task automatic take_command(input cmd_t c);
    logic [7:0]  ch;
    logic [63:0] bitmap;
    frame_t      row;
    if (c.mode == MODE_ENQUEUE) begin
      if ((is_digit(c.char_code) || is_lower(c.char_code) || is_upper(c.char_code))
          && fill < DEPTH) begin
        char_store[wr_ptr] = c.char_code;
        wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
        fill++;
      end
    end else if (fill != 0) begin
      ch = char_store[rd_ptr];
      rd_ptr = (rd_ptr == DEPTH - 1) ? 0 : rd_ptr + 1;
      fill--;
      if (is_digit(ch) || is_lower(ch)) begin
        if (is_digit(ch)) bitmap = BITMAPS[ch - CHAR_DIGIT_FIRST];
        else bitmap = BITMAPS[10 + ch - CHAR_LOWER_FIRST];
        for (int r = 0; r < 8; r++) begin
          row.row_address = 4'(r + 1);
          row.row_pattern = bitmap[63 - 8 * r -: 8];
          row.last_row    = (r == 7);
          expected_rows.push_back(row);
        end
      end
    end
  endtask

  task automatic check_row(input frame_t got);
    frame_t want;
    if (expected_rows.size() == 0) begin
      report($sformatf("unexpected frame row %0d pattern %02h", got.row_address,
                       got.row_pattern));
    end else begin
      want = expected_rows.pop_front();
      if (got.row_address !== want.row_address)
        report($sformatf("row_address %0d, expected %0d", got.row_address,
                         want.row_address));
      if (got.row_pattern !== want.row_pattern)
        report($sformatf("row %0d row_pattern %02h, expected %02h", want.row_address,
                         got.row_pattern, want.row_pattern));
      if (got.last_row !== want.last_row)
        report($sformatf("row %0d last_row %0b, expected %0b", want.row_address,
                         got.last_row, want.last_row));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rd_ptr = 0;
      wr_ptr = 0;
      fill   = 0;
      expected_rows.delete();
    end else begin
      if (frame_valid && frame_ready) check_row(frame_data);
      if (cmd_valid && cmd_ready) take_command(cmd_data);
    end
    pending_rows <= expected_rows.size();
  end

endmodule

>>> bench/tb_glyph_queue_matrix_row_writer.sv
`timescale 1ns / 100ps

// Top of the bench for the glyph queue. It makes the command stimulus, plays
// the frame receiver and gives the verdict; all prediction and comparison is
// done by the row checker that sits beside the block.
module tb_glyph_queue_matrix_row_writer;
  import gqmrw_pkg::*;

  // The slowest run sends roughly 200 ticks of eight rows, each row with its
  // own random stall, plus the long receiver hold; this is far above it.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 290;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_ROW  = 60;
  localparam int DRAIN_CYCLES = 30;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending_rows;
  int   cycles = 0;
  bit   cmd_burst = 1'b0;
  bit   frame_burst = 1'b0;

  gqmrw_stream_if #(.item_t(cmd_t))   cmd_if ();
  gqmrw_stream_if #(.item_t(frame_t)) frame_if ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glyph_queue_matrix_row_writer i_dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_if),
    .frame (frame_if)
  );

  gqmrw_row_checker i_row_check (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_if.valid),
    .cmd_ready    (cmd_if.ready),
    .cmd_data     (cmd_if.data),
    .frame_valid  (frame_if.valid),
    .frame_ready  (frame_if.ready),
    .frame_data   (frame_if.data),
    .fail_count   (fail_count),
    .pending_rows (pending_rows)
  );

  // Offers one command item and returns at the edge where it is taken. The
  // idle gap in front of it is drawn per item; during a burst stretch there
  // is none, so back-to-back items keep valid high across the handshake.
  task automatic send_cmd(input logic m, input logic [7:0] code);
    int   gap;
    cmd_t item;
    gap = cmd_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.mode      = m;
    item.char_code = code;
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= item;
    do @(posedge clk); while (!cmd_if.ready);
    if ($urandom_range(0, 19) == 0) cmd_burst = !cmd_burst;
  endtask

  // Picks a character that the queue accepts. Glyph characters are favored,
  // since upper-case letters are popped without any frame.
  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 4);
    if (sel < 2) return CHAR_DIGIT_FIRST + 8'($urandom_range(0, 9));
    if (sel < 4) return CHAR_LOWER_FIRST + 8'($urandom_range(0, 25));
    return CHAR_UPPER_FIRST + 8'($urandom_range(0, 25));
  endfunction

  // Cycle counter that stops a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_glyph_queue_matrix_row_writer: FAIL");
      $finish;
    end
  end

  // Frame receiver. Outside a burst stretch, each row gets its own random stall before ready rises.
  // Once, after a fixed number of rows, it holds ready low for a long stretch
  // while the sender keeps offering commands, so the output register fills
  // up and the block has to hold off its command input.
  initial begin : frame_sink
    int gap;
    int taken;
    taken = 0;
    frame_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = frame_burst ? 0 : $urandom_range(0, 10);
      if (taken == HOLD_AT_ROW) gap = HOLD_CYCLES;
      if (gap > 0) begin
        frame_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      frame_if.ready <= 1'b1;
      do @(posedge clk); while (!frame_if.valid);
      taken++;
      if ($urandom_range(0, 19) == 0) frame_burst = !frame_burst;
    end
  end

  initial begin : stimulus
    int         counted;
    int         n;
    int         kind;
    logic       m;
    logic [7:0] code;
    rst          <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A tick on an empty queue must produce nothing.
    send_cmd(MODE_TICK, 8'hff);

    // Ends of the digit range and both letter ranges.
    send_cmd(MODE_ENQUEUE, CHAR_DIGIT_FIRST);
    send_cmd(MODE_ENQUEUE, CHAR_DIGIT_LAST);
    send_cmd(MODE_ENQUEUE, CHAR_LOWER_FIRST);
    send_cmd(MODE_ENQUEUE, CHAR_LOWER_LAST);
    send_cmd(MODE_ENQUEUE, CHAR_UPPER_FIRST);
    send_cmd(MODE_ENQUEUE, CHAR_UPPER_LAST);

    // Bytes just outside each range, plus both byte extremes and the first
    // byte with the top bit set; all of these must be ignored.
    send_cmd(MODE_ENQUEUE, CHAR_DIGIT_FIRST - 8'd1);
    send_cmd(MODE_ENQUEUE, CHAR_DIGIT_LAST + 8'd1);
    send_cmd(MODE_ENQUEUE, CHAR_UPPER_FIRST - 8'd1);
    send_cmd(MODE_ENQUEUE, CHAR_UPPER_LAST + 8'd1);
    send_cmd(MODE_ENQUEUE, CHAR_LOWER_FIRST - 8'd1);
    send_cmd(MODE_ENQUEUE, CHAR_LOWER_LAST + 8'd1);
    send_cmd(MODE_ENQUEUE, 8'h00);
    send_cmd(MODE_ENQUEUE, 8'hff);
    send_cmd(MODE_ENQUEUE, 8'h80);

    // Drain: four glyphs, then two upper-case letters popped silently, then
    // one more tick on the now empty queue.
    repeat (7) send_cmd(MODE_TICK, 8'(($urandom)));

    // Random part. Most of it is runs of accepted characters followed by a
    // run of ticks; runs longer than the queue make it overflow and drop
    // bytes, and surplus ticks hit an empty queue. The rest is noise with
    // random modes and random bytes.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          send_cmd(MODE_ENQUEUE, pick_char());
          counted++;
        end
        n = $urandom_range(1, 20);
        repeat (n) begin
          send_cmd(MODE_TICK, 8'(($urandom)));
          counted++;
        end
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          m    = 1'($urandom_range(0, 1));
          code = 8'(($urandom));
          send_cmd(m, code);
          counted++;
        end
      end
    end

    // Let the last glyph drain, then leave room for any stray frame.
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_rows != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_glyph_queue_matrix_row_writer: PASS");
    end else begin
      $display("tb_glyph_queue_matrix_row_writer: FAIL");
    end
    $finish;
  end

endmodule
